/* rtl/lrp_pkg.sv */
// ----------------------------------------------------------------------------
// lrp_pkg
// Types and constants shared by the lidar range to point converter.
// ----------------------------------------------------------------------------
package lrp_pkg;

    localparam int RANGE_BITS       = 20;
    localparam int ANGLE_BITS       = 16;
    localparam int COORD_BITS       = 21;
    localparam int COLUMN_BITS      = 11;
    localparam int ROW_BITS         = 7;
    localparam int CFG_ADDR_BITS    = 3;
    localparam int CFG_DATA_BITS    = 20;
    localparam int COLUMN_COUNT     = 2048;
    localparam int ROW_COUNT        = 128;
    localparam int TRIG_TABLE_DEPTH = 1024;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_AZ_START  = 3'd0,
        CFG_AZ_STEP   = 3'd1,
        CFG_EL_START  = 3'd2,
        CFG_EL_STEP   = 3'd3,
        CFG_RNG_FLOOR = 3'd4,
        CFG_RNG_CEIL  = 3'd5,
        CFG_RNG_CLAMP = 3'd6
    } cfg_addr_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0]  range_raw;
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_BITS-1:0]    row;
    } in_word_t;

    typedef struct packed {
        logic                   kept;
        logic [COORD_BITS-1:0]  pos_x;
        logic [COORD_BITS-1:0]  pos_y;
        logic [COORD_BITS-1:0]  pos_z;
        logic [ANGLE_BITS-1:0]  azimuth;
        logic [ROW_BITS-1:0]    ring;
        logic [RANGE_BITS-1:0]  range_out;
    } out_word_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] az_start;
        logic [ANGLE_BITS-1:0] az_step;
        logic [ANGLE_BITS-1:0] el_start;
        logic [ANGLE_BITS-1:0] el_step;
        logic [RANGE_BITS-1:0] rng_floor;
        logic [RANGE_BITS-1:0] rng_ceil;
        logic [RANGE_BITS-1:0] rng_clamp;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                  kept;
        logic [RANGE_BITS-1:0] range_val;
        logic [ANGLE_BITS-1:0] az;
        logic [ANGLE_BITS-1:0] el;
        logic [ROW_BITS-1:0]   ring;
    } job_t;

endpackage

/* rtl/lrp_front.sv */
// ----------------------------------------------------------------------------
// lrp_front
// Clamps the range, forms the ray angles and applies the range gate.
// ----------------------------------------------------------------------------
module lrp_front
    import lrp_pkg::*;
(
    input  in_word_t in_word,
    input  cfg_t     cfg,
    output job_t     job
);

    logic [RANGE_BITS-1:0] r;
    logic [ANGLE_BITS-1:0] az_prod;
    logic [ANGLE_BITS-1:0] el_prod;
    logic                  col_ok;
    logic                  row_ok;

    always_comb begin
        r       = (in_word.range_raw > cfg.rng_clamp) ? cfg.rng_clamp : in_word.range_raw;
        az_prod = ANGLE_BITS'({{(ANGLE_BITS-COLUMN_BITS){1'b0}}, in_word.column} * cfg.az_step);
        el_prod = ANGLE_BITS'({{(ANGLE_BITS-ROW_BITS){1'b0}}, in_word.row} * cfg.el_step);
        col_ok  = 32'(in_word.column) < 32'(COLUMN_COUNT);
        row_ok  = 32'(in_word.row) < 32'(ROW_COUNT);
        job.kept      = (cfg.rng_floor < r) && (r < cfg.rng_ceil) && col_ok && row_ok;
        job.range_val = r;
        job.az        = cfg.az_start + az_prod;
        job.el        = cfg.el_start + el_prod;
        job.ring      = in_word.row;
    end

endmodule

/* rtl/lrp_queue.sv */
// ----------------------------------------------------------------------------
// lrp_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module lrp_queue
    import lrp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t pop_job
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    job_t                  mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]     count_reg, count_next;

    assign full    = count_reg == (PTR_BITS+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/lrp_back.sv */
// ----------------------------------------------------------------------------
// lrp_back
// Sine lookup and the product stages, ending in the output register.
// ----------------------------------------------------------------------------
module lrp_back
    import lrp_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = lrp_pkg::TRIG_TABLE_DEPTH
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      empty,
    input  job_t      pop_job,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int IDX_BITS  = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int PROD_BITS = 15 + IDX_BITS;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
          64'd342, 64'd420};

    typedef logic [14:0] rom_t [0:TRIG_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned t;
        longint unsigned u;
        longint          s;
        longint unsigned v;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            t = (longint'(k) * HALF_PI_Q30) / TRIG_TABLE_DEPTH;
            u = t;
            s = longint'(t);
            for (int n = 1; n <= 10; n++) begin
                u = (u * t) >> 30;
                u = ((u * t) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    s = s - longint'(u);
                end else begin
                    s = s + longint'(u);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            v = (longint'(s) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = 15'(v);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic adv;

    // lane 0 sin az, 1 cos az, 2 sin el, 3 cos el
    logic [ANGLE_BITS-1:0] lane_angle [4];
    logic [14:0]           rom_q_reg  [4];
    logic                  neg_reg    [4];
    job_t                  s1_job_reg;
    logic                  s1_valid_reg;

    logic signed [16:0]    sv [4];
    logic signed [37:0]    c_prod_reg, z_prod_reg;
    logic signed [16:0]    cos_az_reg, sin_az_reg;
    job_t                  s2_job_reg;
    logic                  s2_valid_reg;

    logic signed [20:0]    c_val;
    logic signed [37:0]    x_prod_reg, y_prod_reg;
    logic signed [20:0]    z_reg;
    job_t                  s3_job_reg;
    logic                  s3_valid_reg;

    out_word_t             out_reg;
    logic                  out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign pop     = adv && !empty;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign lane_angle[0] = pop_job.az;
    assign lane_angle[1] = pop_job.az + 16'd16384;
    assign lane_angle[2] = pop_job.el;
    assign lane_angle[3] = pop_job.el + 16'd16384;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [14:0]          frac;
        logic [14:0]          u;
        logic [PROD_BITS-1:0] idx_prod;
        logic [IDX_BITS-1:0]  idx;

        always_comb begin
            frac     = {1'b0, lane_angle[g][13:0]};
            u        = lane_angle[g][14] ? 15'd16384 - frac : frac;
            idx_prod = PROD_BITS'(u) * PROD_BITS'(TRIG_TABLE_DEPTH);
            idx      = IDX_BITS'(idx_prod >> 14);
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rom_q_reg[g] <= SINE_ROM[idx];
                neg_reg[g]   <= lane_angle[g][15];
            end
        end

        assign sv[g] = neg_reg[g] ? -$signed({2'b00, rom_q_reg[g]})
                                  : $signed({2'b00, rom_q_reg[g]});
    end

    assign c_val = c_prod_reg[35:15];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_job_reg <= pop_job;

            s2_job_reg <= s1_job_reg;
            c_prod_reg <= $signed({1'b0, s1_job_reg.range_val}) * sv[3];
            z_prod_reg <= $signed({1'b0, s1_job_reg.range_val}) * sv[2];
            cos_az_reg <= sv[1];
            sin_az_reg <= sv[0];

            s3_job_reg <= s2_job_reg;
            x_prod_reg <= c_val * cos_az_reg;
            y_prod_reg <= c_val * sin_az_reg;
            z_reg      <= z_prod_reg[35:15];

            out_reg.kept      <= s3_job_reg.kept;
            out_reg.pos_x     <= s3_job_reg.kept ? x_prod_reg[35:15] : '0;
            out_reg.pos_y     <= s3_job_reg.kept ? y_prod_reg[35:15] : '0;
            out_reg.pos_z     <= s3_job_reg.kept ? z_reg : '0;
            out_reg.azimuth   <= s3_job_reg.az;
            out_reg.ring      <= s3_job_reg.ring;
            out_reg.range_out <= s3_job_reg.range_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

endmodule

/* rtl/lidar_range_to_point.sv */
// ----------------------------------------------------------------------------
// lidar_range_to_point
// Converts lidar range samples to gated Cartesian points.
// ----------------------------------------------------------------------------
// Input words (range, column, row) arrive on s_valid/s_ready; one result word
// per input leaves on m_valid/m_ready. Registers are written through
// cfg_wr_en/cfg_addr/cfg_wr_data; the user must write them only while no word
// is in flight, which the block does not enforce. The front clamps and gates
// the range and forms the angles in the accept cycle, writing a 4-entry queue.
// The back pops one word a cycle, unless m_valid is high and m_ready low,
// through a sine ROM read and two multiply stages into the output register.
// While the back holds, the queue absorbs up to 4 more words before s_ready
// drops. Reset empties queue and pipeline and loads the register defaults;
// the sine ROM is constant and needs no fill.
// ----------------------------------------------------------------------------
module lidar_range_to_point
    import lrp_pkg::*;
#(
    parameter int TRIG_TABLE_DEPTH = lrp_pkg::TRIG_TABLE_DEPTH
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_word_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_word_t                m_data,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data
);

    cfg_t cfg_reg;
    job_t front_job;
    job_t pop_job;
    logic full;
    logic empty;
    logic pop;
    logic push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.az_start  <= 16'd0;
            cfg_reg.az_step   <= 16'd32;
            cfg_reg.el_start  <= 16'd0;
            cfg_reg.el_step   <= 16'd256;
            cfg_reg.rng_floor <= '0;
            cfg_reg.rng_ceil  <= '1;
            cfg_reg.rng_clamp <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_AZ_START:  cfg_reg.az_start  <= cfg_wr_data[ANGLE_BITS-1:0];
                CFG_AZ_STEP:   cfg_reg.az_step   <= cfg_wr_data[ANGLE_BITS-1:0];
                CFG_EL_START:  cfg_reg.el_start  <= cfg_wr_data[ANGLE_BITS-1:0];
                CFG_EL_STEP:   cfg_reg.el_step   <= cfg_wr_data[ANGLE_BITS-1:0];
                CFG_RNG_FLOOR: cfg_reg.rng_floor <= cfg_wr_data[RANGE_BITS-1:0];
                CFG_RNG_CEIL:  cfg_reg.rng_ceil  <= cfg_wr_data[RANGE_BITS-1:0];
                CFG_RNG_CLAMP: cfg_reg.rng_clamp <= cfg_wr_data[RANGE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !full;
    assign push    = s_valid && !full;

    lrp_front u_front (
        .in_word (s_data),
        .cfg     (cfg_reg),
        .job     (front_job)
    );

    lrp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_job  (pop_job)
    );

    lrp_back #(
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .pop_job (pop_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/sv/tb_lidar_range_to_point.sv */
// ----------------------------------------------------------------------------
// tb_lidar_range_to_point
// Self-checking bench for the lidar range to point converter. Range samples
// are sent through directed and random tests under several register
// settings. Each result word is compared, field by field, with the point
// computed by a built-in predictor. Both sides idle at random except in one run.
// ----------------------------------------------------------------------------
module tb_lidar_range_to_point;
    import lrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED = 3'd7;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  PIPE_LATENCY   = 8;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;

    cfg_t      regs;
    longint    sine_rom[TRIG_TABLE_DEPTH+1];
    out_word_t pending_points[$];
    int        errors = 0;
    int        stall_cycles = 0;
    bit        idle_on = 1'b1;

    lidar_range_to_point uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic void build_sine_rom();
        longint unsigned t, u, v;
        longint s;
        for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
            t = (longint'(k) * HALF_PI_Q30) / TRIG_TABLE_DEPTH;
            u = t;
            s = longint'(t);
            for (int n = 1; n <= 10; n++) begin
                u = (u * t) >> 30;
                u = ((u * t) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) s = s - longint'(u);
                else s = s + longint'(u);
            end
            if (s < 0) s = 0;
            v = (longint'(s) + 16384) >> 15;
            if (v > 32767) v = 32767;
            sine_rom[k] = longint'(v);
        end
    endfunction

    function automatic longint rom_at(longint u);
        longint idx;
        idx = (u * TRIG_TABLE_DEPTH) / 16384;
        if (idx > TRIG_TABLE_DEPTH) idx = TRIG_TABLE_DEPTH;
        return sine_rom[idx];
    endfunction

    function automatic longint sine_q15(logic [ANGLE_BITS-1:0] a);
        longint f, v;
        f = longint'(a[13:0]);
        v = a[14] ? rom_at(16384 - f) : rom_at(f);
        return a[15] ? -v : v;
    endfunction

    function automatic out_word_t point_of(in_word_t w);
        out_word_t p;
        logic [RANGE_BITS-1:0] r;
        logic [ANGLE_BITS-1:0] az, el, az_cos, el_cos;
        longint c, x, y, z;
        r = (w.range_raw > regs.rng_clamp) ? regs.rng_clamp : w.range_raw;
        az = regs.az_start + ANGLE_BITS'(w.column) * regs.az_step;
        el = regs.el_start + ANGLE_BITS'(w.row) * regs.el_step;
        az_cos = az + 16'd16384;
        el_cos = el + 16'd16384;
        x = 0; y = 0; z = 0;
        p.kept = (regs.rng_floor < r) && (r < regs.rng_ceil) &&
                 (w.column < COLUMN_COUNT) && (w.row < ROW_COUNT);
        if (p.kept) begin
            c = (longint'(r) * sine_q15(el_cos)) >>> 15;
            x = (c * sine_q15(az_cos)) >>> 15;
            y = (c * sine_q15(az)) >>> 15;
            z = (longint'(r) * sine_q15(el)) >>> 15;
        end
        p.pos_x = x[COORD_BITS-1:0];
        p.pos_y = y[COORD_BITS-1:0];
        p.pos_z = z[COORD_BITS-1:0];
        p.azimuth = az;
        p.ring = w.row;
        p.range_out = r;
        return p;
    endfunction

    // ---------------- result side ----------------
    always @(posedge aclk) begin
        m_ready <= (idle_on && $urandom_range(99) < 11) ? 1'b0 : 1'b1;
    end

    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_data);
                errors++;
            end else begin
                e = pending_points.pop_front();
                if (m_data.kept !== e.kept) begin
                    $display("%0t: kept exp %0d act %0d", $time, e.kept, m_data.kept);
                    errors++;
                end
                if (m_data.pos_x !== e.pos_x) begin
                    $display("%0t: pos_x exp %h act %h", $time, e.pos_x, m_data.pos_x);
                    errors++;
                end
                if (m_data.pos_y !== e.pos_y) begin
                    $display("%0t: pos_y exp %h act %h", $time, e.pos_y, m_data.pos_y);
                    errors++;
                end
                if (m_data.pos_z !== e.pos_z) begin
                    $display("%0t: pos_z exp %h act %h", $time, e.pos_z, m_data.pos_z);
                    errors++;
                end
                if (m_data.azimuth !== e.azimuth) begin
                    $display("%0t: azimuth exp %h act %h", $time, e.azimuth,
                             m_data.azimuth);
                    errors++;
                end
                if (m_data.ring !== e.ring) begin
                    $display("%0t: ring exp %0d act %0d", $time, e.ring, m_data.ring);
                    errors++;
                end
                if (m_data.range_out !== e.range_out) begin
                    $display("%0t: range_out exp %h act %h", $time, e.range_out,
                             m_data.range_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_word(in_word_t w);
        if (idle_on && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 11);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_points.push_back(point_of(w));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_AZ_START:  regs.az_start  = d[ANGLE_BITS-1:0];
            CFG_AZ_STEP:   regs.az_step   = d[ANGLE_BITS-1:0];
            CFG_EL_START:  regs.el_start  = d[ANGLE_BITS-1:0];
            CFG_EL_STEP:   regs.el_step   = d[ANGLE_BITS-1:0];
            CFG_RNG_FLOOR: regs.rng_floor = d;
            CFG_RNG_CEIL:  regs.rng_ceil  = d;
            CFG_RNG_CLAMP: regs.rng_clamp = d;
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [15:0] azs, logic [15:0] azd, logic [15:0] els,
                             logic [15:0] eld, logic [19:0] fl, logic [19:0] ce,
                             logic [19:0] cl);
        write_reg(CFG_AZ_START, CFG_DATA_BITS'(azs));
        write_reg(CFG_AZ_STEP, CFG_DATA_BITS'(azd));
        write_reg(CFG_EL_START, CFG_DATA_BITS'(els));
        write_reg(CFG_EL_STEP, CFG_DATA_BITS'(eld));
        write_reg(CFG_RNG_FLOOR, fl);
        write_reg(CFG_RNG_CEIL, ce);
        write_reg(CFG_RNG_CLAMP, cl);
    endtask

    function automatic in_word_t random_word();
        in_word_t w;
        w.column = COLUMN_BITS'($urandom_range(COLUMN_COUNT - 1));
        w.row    = ROW_BITS'($urandom_range(ROW_COUNT - 1));
        case ($urandom_range(3))
            0: w.range_raw = RANGE_BITS'(regs.rng_floor + $urandom_range(2) - 1);
            1: w.range_raw = RANGE_BITS'(regs.rng_ceil + $urandom_range(2) - 1);
            2: w.range_raw = RANGE_BITS'(regs.rng_clamp + $urandom_range(2) - 1);
            default: w.range_raw = RANGE_BITS'($urandom);
        endcase
        if ($urandom_range(1)) w.range_raw = RANGE_BITS'($urandom);
        return w;
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) begin
            send_word(random_word());
            if ($urandom_range(199) == 0) drain();
        end
        drain();
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        send_word('{range_raw: 20'd0, column: 11'd0, row: 7'd0});
        send_word('{range_raw: 20'd1, column: 11'd0, row: 7'd0});
        send_word('{range_raw: 20'hFFFFF, column: 11'd2047, row: 7'd127});
        send_word('{range_raw: 20'hFFFFE, column: 11'd2047, row: 7'd0});
        send_word('{range_raw: 20'h80000, column: 11'd512, row: 7'd64});
        send_word('{range_raw: 20'h12345, column: 11'd1024, row: 7'd32});
        drain();
    endtask

    task automatic test_quadrants();
        load_regs(16'h0000, 16'h4000, 16'h0000, 16'h4000, 20'd0, 20'hFFFFF, 20'hFFFFF);
        for (int q = 0; q < 4; q++) begin
            send_word('{range_raw: 20'hFFFFE, column: 11'(q), row: 7'(q)});
            send_word('{range_raw: 20'h40000, column: 11'(q), row: 7'((q + 1) % 4)});
        end
        drain();
    endtask

    task automatic test_gates();
        load_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 20'd100, 20'd200, 20'd150);
        send_word('{range_raw: 20'd100, column: 11'd1, row: 7'd1});
        send_word('{range_raw: 20'd101, column: 11'd2047, row: 7'd127});
        send_word('{range_raw: 20'd150, column: 11'd3, row: 7'd2});
        send_word('{range_raw: 20'hFFFFF, column: 11'd5, row: 7'd5});
        drain();
        write_reg(CFG_UNUSED, 20'hFFFFF);
        write_reg(CFG_RNG_CEIL, 20'd100);
        send_word('{range_raw: 20'd120, column: 11'd7, row: 7'd9});
        drain();
        write_reg(CFG_RNG_CLAMP, 20'd0);
        send_word('{range_raw: 20'hFFFFF, column: 11'd7, row: 7'd9});
        drain();
    endtask

    task automatic test_random_settings();
        load_regs(16'h0000, 16'h0020, 16'h0000, 16'h0100, 20'd0, 20'hFFFFF, 20'hFFFFF);
        send_random(300);
        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  20'($urandom_range(4000)), 20'(20'hF0000 + $urandom_range(65535)),
                  20'($urandom));
        send_random(300);
        idle_on = 1'b0;
        load_regs(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001, 20'd0, 20'hFFFFF, 20'hFFFFF);
        send_random(300);
        idle_on = 1'b1;
        load_regs(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 20'hFFFFF, 20'd0, 20'hFFFFF);
        send_random(150);
        for (int i = 0; i < 2; i++) begin
            load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      20'($urandom_range(20000)), 20'($urandom), 20'($urandom));
            send_random(300);
        end
    endtask

    initial begin
        build_sine_rom();
        regs = '{az_start: 16'd0, az_step: 16'd32, el_start: 16'd0, el_step: 16'd256,
                 rng_floor: 20'd0, rng_ceil: 20'hFFFFF, rng_clamp: 20'hFFFFF};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_quadrants();
        test_gates();
        test_random_settings();
        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
